// ===== hdl/assert_macros.svh =====
// Assertion macros for the compatibility distance core.
// Clocked on clk, disabled while rst_n is low; used by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in compatibility distance core");

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed in compatibility distance core");

`endif

// ===== hdl/ncd_pkg.sv =====
// Shared types and constants for the compatibility distance core.
// No dependencies; used by the front end, queue, back end, top level and testbench.
`timescale 1ns / 1ps

package ncd_pkg;

  localparam int MAX_GENES = 1023;
  localparam logic [16:0] MAX_GENES_W = 17'(MAX_GENES);
  localparam logic [9:0] TALLY_CAP = (MAX_GENES < 1023) ? 10'(MAX_GENES) : 10'd1023;

  localparam int GAP_W = 27;
  localparam logic [GAP_W-1:0] GAP_CAP = {GAP_W{1'b1}};
  localparam logic [23:0] DIST_CAP = 24'hFFFFFF;

  localparam int DIV_STEPS = GAP_W;
  localparam int DIV_CW = $clog2(DIV_STEPS);

  // queue depth must stay a power of two: pointers wrap by truncation
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

  localparam int CFG_IW = 3;

  typedef enum logic [CFG_IW-1:0] {
    CFG_COEFF_EXCESS   = 3'd0,
    CFG_COEFF_DISJOINT = 3'd1,
    CFG_COEFF_WEIGHT   = 3'd2,
    CFG_THRESHOLD      = 3'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    CLS_NONE     = 2'd0,
    CLS_MATCH    = 2'd1,
    CLS_EXCESS   = 2'd2,
    CLS_DISJOINT = 2'd3
  } gene_cls_t;

  typedef struct packed {
    gene_cls_t   cls;
    logic [15:0] gap;
    logic        final_slot;
  } slot_word_t;

  typedef struct packed {
    logic               full;
    logic               empty;
    logic [FIFO_CW-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic computing;
    logic result_waiting;
  } back_stat_t;

endpackage

// ===== hdl/ncd_if.sv =====
// Valid/ready channel interfaces for slot words in and distance results out.
// Field widths follow the item layout; no package dependency.
`timescale 1ns / 1ps

interface ncd_in_if;
  logic               valid;
  logic               ready;
  logic [9:0]         slot_number;
  logic               ref_present;
  logic               cand_present;
  logic signed [15:0] ref_weight;
  logic signed [15:0] cand_weight;
  logic [9:0]         ref_top;
  logic [9:0]         cand_top;
  logic               final_slot;

  modport source (
    output valid, slot_number, ref_present, cand_present, ref_weight, cand_weight,
           ref_top, cand_top, final_slot,
    input  ready
  );
  modport sink (
    input  valid, slot_number, ref_present, cand_present, ref_weight, cand_weight,
           ref_top, cand_top, final_slot,
    output ready
  );
endinterface

interface ncd_out_if;
  logic        valid;
  logic        ready;
  logic        same_species;
  logic [23:0] distance_value;
  logic [9:0]  matching_count;
  logic [9:0]  excess_count;
  logic [9:0]  disjoint_count;

  modport source (
    output valid, same_species, distance_value, matching_count, excess_count,
           disjoint_count,
    input  ready
  );
  modport sink (
    input  valid, same_species, distance_value, matching_count, excess_count,
           disjoint_count,
    output ready
  );
endinterface

// ===== hdl/ncd_front.sv =====
// Front end: accepts slot words and classes each gene slot.
// Depends on ncd_pkg and ncd_in_if; feeds the slot queue.
`timescale 1ns / 1ps

module ncd_front (
  ncd_in_if.sink            in_ch,
  input  logic              q_full,
  output logic              q_push,
  output ncd_pkg::slot_word_t q_word
);

  logic               slot_ok;
  logic signed [16:0] diff;

  always_comb begin
    slot_ok = (in_ch.slot_number != 10'd0) &&
              ({7'd0, in_ch.slot_number} <= ncd_pkg::MAX_GENES_W);
    diff = {in_ch.ref_weight[15], in_ch.ref_weight} -
           {in_ch.cand_weight[15], in_ch.cand_weight};

    q_word.final_slot = in_ch.final_slot;
    q_word.gap = diff[16] ? 16'(-diff) : diff[15:0];

    if (!slot_ok) begin
      q_word.cls = ncd_pkg::CLS_NONE;
    end else if (in_ch.ref_present && in_ch.cand_present) begin
      q_word.cls = ncd_pkg::CLS_MATCH;
    end else if (in_ch.ref_present) begin
      // excess when beyond the other genome's highest innovation
      q_word.cls = (in_ch.slot_number > in_ch.cand_top) ? ncd_pkg::CLS_EXCESS
                                                        : ncd_pkg::CLS_DISJOINT;
    end else if (in_ch.cand_present) begin
      q_word.cls = (in_ch.slot_number > in_ch.ref_top) ? ncd_pkg::CLS_EXCESS
                                                       : ncd_pkg::CLS_DISJOINT;
    end else begin
      q_word.cls = ncd_pkg::CLS_NONE;
    end
  end

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

endmodule

// ===== hdl/ncd_fifo.sv =====
// Short queue of classed slot words between front and back ends.
// Depends on ncd_pkg for the word type and depth.
`timescale 1ns / 1ps

module ncd_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ncd_pkg::slot_word_t push_word,
  input  logic                pop,
  output ncd_pkg::slot_word_t pop_word,
  output ncd_pkg::fifo_stat_t stat
);

  ncd_pkg::slot_word_t                 mem_r [ncd_pkg::FIFO_DEPTH];
  logic [ncd_pkg::FIFO_AW-1:0]         wr_ptr_r, rd_ptr_r;
  logic [ncd_pkg::FIFO_CW-1:0]         count_r;
  logic                                do_push, do_pop;

  assign stat.full  = (count_r == ncd_pkg::FIFO_CW'(ncd_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

  assign do_push  = push && !stat.full;
  assign do_pop   = pop && !stat.empty;
  assign pop_word = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== hdl/ncd_back.sv =====
// Back end: tallies classed slots, then divides, scales and sums on a final slot.
// Depends on ncd_pkg and ncd_out_if; holds the configuration registers.
`timescale 1ns / 1ps

module ncd_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ncd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [23:0]              cfg_wdata,
  input  ncd_pkg::slot_word_t      q_word,
  input  logic                     q_empty,
  output logic                     q_pop,
  output ncd_pkg::back_stat_t      stat,
  ncd_out_if.source                out_ch
);

  typedef enum logic [3:0] {
    ST_ACC = 4'b0001,
    ST_DIV = 4'b0010,
    ST_MUL = 4'b0100,
    ST_SUM = 4'b1000
  } back_state_t;

  back_state_t state_r;

  logic [15:0] coeff_excess_r, coeff_disjoint_r, coeff_weight_r;
  logic [23:0] threshold_r;

  logic [9:0]               match_r, excess_r, disjoint_r;
  logic [9:0]               match_nxt, excess_nxt, disjoint_nxt;
  logic [ncd_pkg::GAP_W-1:0] gap_sum_r, gap_sum_nxt;
  logic [ncd_pkg::GAP_W:0]   gap_wide;

  logic [9:0]               snap_match_r, snap_excess_r, snap_disjoint_r;
  logic [ncd_pkg::GAP_W-1:0] quot_r;
  logic [9:0]               rem_r;
  logic [10:0]              trial;
  logic                     trial_ge;
  logic [ncd_pkg::DIV_CW-1:0] step_r;

  logic [ncd_pkg::GAP_W-1:0] mean;
  logic [25:0]              prod_e_r, prod_d_r;
  logic [ncd_pkg::GAP_W+15:0] prod_w_r;
  logic [31:0]              dist_sum;
  logic                     out_free;

  logic        out_valid_r, same_r;
  logic [23:0] dist_r;
  logic [9:0]  out_match_r, out_excess_r, out_disjoint_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_excess_r   <= 16'd4096;
      coeff_disjoint_r <= 16'd4096;
      coeff_weight_r   <= 16'd4096;
      threshold_r      <= 24'd12288;
    end else if (cfg_we) begin
      case (cfg_index)
        ncd_pkg::CFG_COEFF_EXCESS:   coeff_excess_r   <= cfg_wdata[15:0];
        ncd_pkg::CFG_COEFF_DISJOINT: coeff_disjoint_r <= cfg_wdata[15:0];
        ncd_pkg::CFG_COEFF_WEIGHT:   coeff_weight_r   <= cfg_wdata[15:0];
        ncd_pkg::CFG_THRESHOLD:      threshold_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // saturating tallies for the word at the queue head
  always_comb begin
    match_nxt    = match_r;
    excess_nxt   = excess_r;
    disjoint_nxt = disjoint_r;
    gap_wide     = {1'b0, gap_sum_r} + {{(ncd_pkg::GAP_W-15){1'b0}}, q_word.gap};
    gap_sum_nxt  = gap_sum_r;
    case (q_word.cls)
      ncd_pkg::CLS_MATCH: begin
        if (match_r < ncd_pkg::TALLY_CAP) match_nxt = match_r + 1'b1;
        gap_sum_nxt = gap_wide[ncd_pkg::GAP_W] ? ncd_pkg::GAP_CAP
                                               : gap_wide[ncd_pkg::GAP_W-1:0];
      end
      ncd_pkg::CLS_EXCESS: begin
        if (excess_r < ncd_pkg::TALLY_CAP) excess_nxt = excess_r + 1'b1;
      end
      ncd_pkg::CLS_DISJOINT: begin
        if (disjoint_r < ncd_pkg::TALLY_CAP) disjoint_nxt = disjoint_r + 1'b1;
      end
      default: ;
    endcase
  end

  assign q_pop = (state_r == ST_ACC) && !q_empty;

  // restoring divide, one quotient bit a cycle
  assign trial    = {rem_r, quot_r[ncd_pkg::GAP_W-1]};
  assign trial_ge = (trial >= {1'b0, snap_match_r});

  assign mean     = (snap_match_r == 10'd0) ? '0 : quot_r;
  assign dist_sum = 32'(prod_e_r) + 32'(prod_d_r) + 32'(prod_w_r[ncd_pkg::GAP_W+15:12]);
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      match_r     <= '0;
      excess_r    <= '0;
      disjoint_r  <= '0;
      gap_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the sum state reloads the output register itself when it is free
      if (out_valid_r && out_ch.ready && (state_r != ST_SUM)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_ACC: begin
          if (q_pop) begin
            if (q_word.final_slot) begin
              // snapshot this comparison and clear for the next one
              snap_match_r    <= match_nxt;
              snap_excess_r   <= excess_nxt;
              snap_disjoint_r <= disjoint_nxt;
              quot_r          <= gap_sum_nxt;
              rem_r           <= '0;
              step_r          <= '0;
              match_r         <= '0;
              excess_r        <= '0;
              disjoint_r      <= '0;
              gap_sum_r       <= '0;
              state_r         <= ST_DIV;
            end else begin
              match_r    <= match_nxt;
              excess_r   <= excess_nxt;
              disjoint_r <= disjoint_nxt;
              gap_sum_r  <= gap_sum_nxt;
            end
          end
        end
        ST_DIV: begin
          rem_r  <= trial_ge ? 10'(trial - {1'b0, snap_match_r}) : trial[9:0];
          quot_r <= {quot_r[ncd_pkg::GAP_W-2:0], trial_ge};
          step_r <= step_r + 1'b1;
          if (step_r == ncd_pkg::DIV_CW'(ncd_pkg::DIV_STEPS - 1)) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_e_r <= coeff_excess_r * snap_excess_r;
          prod_d_r <= coeff_disjoint_r * snap_disjoint_r;
          prod_w_r <= coeff_weight_r * mean;
          state_r  <= ST_SUM;
        end
        ST_SUM: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r    <= 1'b1;
            same_r         <= (dist_sum <= {8'd0, threshold_r});
            dist_r         <= (dist_sum > {8'd0, ncd_pkg::DIST_CAP}) ? ncd_pkg::DIST_CAP
                                                                     : dist_sum[23:0];
            out_match_r    <= snap_match_r;
            out_excess_r   <= snap_excess_r;
            out_disjoint_r <= snap_disjoint_r;
            state_r        <= ST_ACC;
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

  assign stat.computing      = (state_r != ST_ACC);
  assign stat.result_waiting = out_valid_r;

  assign out_ch.valid          = out_valid_r;
  assign out_ch.same_species   = same_r;
  assign out_ch.distance_value = dist_r;
  assign out_ch.matching_count = out_match_r;
  assign out_ch.excess_count   = out_excess_r;
  assign out_ch.disjoint_count = out_disjoint_r;

endmodule

// ===== hdl/neat_compatibility_distance_core.sv =====
// Compatibility distance core: one gene slot word accepted per cycle while the queue has room.
// A final slot sends the back end through a restoring divide, a multiply and a sum,
// and the sum waits for a free output register; the queue absorbs up to 4 words meanwhile.
// Slot words of the next comparison keep entering the queue while the back end computes, until it is full.
// Synchronous active-low reset clears tallies, queue and output, and loads default coefficients.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module neat_compatibility_distance_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ncd_pkg::CFG_IW-1:0] cfg_index,
  input  logic [23:0]              cfg_wdata,
  ncd_in_if.sink                   in_ch,
  ncd_out_if.source                out_ch
);

  ncd_pkg::slot_word_t push_word, pop_word;
  ncd_pkg::fifo_stat_t fifo_stat;
  ncd_pkg::back_stat_t back_stat;
  logic                push, pop;

  ncd_front u_front (
    .in_ch  (in_ch),
    .q_full (fifo_stat.full),
    .q_push (push),
    .q_word (push_word)
  );

  ncd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .stat      (fifo_stat)
  );

  ncd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_word    (pop_word),
    .q_empty   (fifo_stat.empty),
    .q_pop     (pop),
    .stat      (back_stat),
    .out_ch    (out_ch)
  );

  `ASSERT_SAME(a_no_pop_while_computing, pop, !back_stat.computing && !fifo_stat.empty)
  `ASSERT_SAME(a_fifo_bounded, 1'b1, fifo_stat.count <= ncd_pkg::FIFO_CW'(ncd_pkg::FIFO_DEPTH))
  `ASSERT_NEXT(a_final_starts_compute, pop && pop_word.final_slot, back_stat.computing)

endmodule

// ===== tb/tb.sv =====
// Testbench for the compatibility distance core: drives gene slot words and configuration.
// A scoreboard class predicts each distance result and checks it field by field.
// Depends on ncd_pkg, the ncd_in_if / ncd_out_if interfaces and the core itself.
`timescale 1ns / 1ps

module tb;
  import ncd_pkg::*;

  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [9:0]         slot_number;
    logic               ref_present;
    logic               cand_present;
    logic signed [15:0] ref_weight;
    logic signed [15:0] cand_weight;
    logic [9:0]         ref_top;
    logic [9:0]         cand_top;
    logic               final_slot;
  } slot_t;

  typedef struct packed {
    logic        same_species;
    logic [23:0] distance_value;
    logic [9:0]  matching_count;
    logic [9:0]  excess_count;
    logic [9:0]  disjoint_count;
  } verdict_t;

  class distance_scoreboard;
    logic [15:0] coeff_exc;
    logic [15:0] coeff_dis;
    logic [15:0] coeff_wt;
    logic [23:0] threshold;
    logic [9:0]  n_match;
    logic [9:0]  n_excess;
    logic [9:0]  n_disjoint;
    logic [26:0] gap_sum;
    verdict_t    expected_q[$];
    int          errors;

    function new();
      coeff_exc  = 16'd4096;
      coeff_dis  = 16'd4096;
      coeff_wt   = 16'd4096;
      threshold  = 24'd12288;
      n_match    = '0;
      n_excess   = '0;
      n_disjoint = '0;
      gap_sum    = '0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [23:0] val);
      case (idx)
        CFG_COEFF_EXCESS:   coeff_exc = val[15:0];
        CFG_COEFF_DISJOINT: coeff_dis = val[15:0];
        CFG_COEFF_WEIGHT:   coeff_wt  = val[15:0];
        CFG_THRESHOLD:      threshold = val;
        default: ;
      endcase
    endfunction

    // Classify one accepted slot word; on a final word queue the expected distance.
    function void note_slot(slot_t s);
      gene_cls_t   cls;
      int          d;
      logic [27:0] sum_w;
      logic [63:0] mean;
      logic [63:0] dist_sum;
      verdict_t    v;
      cls = CLS_NONE;
      if (s.slot_number != 0 && s.slot_number <= MAX_GENES) begin
        if (s.ref_present && s.cand_present) cls = CLS_MATCH;
        else if (s.ref_present) cls = (s.slot_number > s.cand_top) ? CLS_EXCESS : CLS_DISJOINT;
        else if (s.cand_present) cls = (s.slot_number > s.ref_top) ? CLS_EXCESS : CLS_DISJOINT;
      end
      case (cls)
        CLS_MATCH: begin
          d = int'($signed(s.ref_weight)) - int'($signed(s.cand_weight));
          if (d < 0) d = -d;
          if (n_match < TALLY_CAP) n_match++;
          sum_w = {1'b0, gap_sum} + 28'(d);
          gap_sum = (sum_w > {1'b0, GAP_CAP}) ? GAP_CAP : sum_w[26:0];
        end
        CLS_EXCESS:   if (n_excess < TALLY_CAP) n_excess++;
        CLS_DISJOINT: if (n_disjoint < TALLY_CAP) n_disjoint++;
        default: ;
      endcase
      if (!s.final_slot) return;
      mean = (n_match != 0) ? 64'(gap_sum) / 64'(n_match) : 64'd0;
      dist_sum = 64'(coeff_exc) * 64'(n_excess) + 64'(coeff_dis) * 64'(n_disjoint)
               + ((64'(coeff_wt) * mean) >> 12);
      v.same_species   = (dist_sum <= 64'(threshold));
      v.distance_value = (dist_sum > 64'(DIST_CAP)) ? DIST_CAP : dist_sum[23:0];
      v.matching_count = n_match;
      v.excess_count   = n_excess;
      v.disjoint_count = n_disjoint;
      expected_q.push_back(v);
      n_match    = '0;
      n_excess   = '0;
      n_disjoint = '0;
      gap_sum    = '0;
    endfunction

    function void check_result(verdict_t got);
      verdict_t exp_v;
      if (expected_q.size() == 0) begin
        $error("distance result with nothing expected: distance_value %0d",
               got.distance_value);
        errors++;
        return;
      end
      exp_v = expected_q.pop_front();
      if (got.same_species !== exp_v.same_species) begin
        $error("same_species: expected %0d, actual %0d", exp_v.same_species, got.same_species);
        errors++;
      end
      if (got.distance_value !== exp_v.distance_value) begin
        $error("distance_value: expected %0d, actual %0d",
               exp_v.distance_value, got.distance_value);
        errors++;
      end
      if (got.matching_count !== exp_v.matching_count) begin
        $error("matching_count: expected %0d, actual %0d",
               exp_v.matching_count, got.matching_count);
        errors++;
      end
      if (got.excess_count !== exp_v.excess_count) begin
        $error("excess_count: expected %0d, actual %0d", exp_v.excess_count, got.excess_count);
        errors++;
      end
      if (got.disjoint_count !== exp_v.disjoint_count) begin
        $error("disjoint_count: expected %0d, actual %0d",
               exp_v.disjoint_count, got.disjoint_count);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [23:0]         cfg_wdata;
  ncd_in_if            in_ch();
  ncd_out_if           out_ch();

  distance_scoreboard  sb = new();
  int                  src_idle_pct;
  int                  snk_idle_pct;
  int                  counted_slots;

  neat_compatibility_distance_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result side: check each accepted word, then pick the next ready at random.
  initial begin : result_sink
    verdict_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.same_species   = out_ch.same_species;
        got.distance_value = out_ch.distance_value;
        got.matching_count = out_ch.matching_count;
        got.excess_count   = out_ch.excess_count;
        got.disjoint_count = out_ch.disjoint_count;
        sb.check_result(got);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  function automatic slot_t random_slot();
    slot_t s;
    s.slot_number  = 10'($urandom_range(0, 1023));
    s.ref_present  = 1'($urandom);
    s.cand_present = 1'($urandom);
    s.ref_weight   = 16'($urandom);
    s.cand_weight  = 16'($urandom);
    s.ref_top      = 10'($urandom);
    s.cand_top     = 10'($urandom);
    s.final_slot   = ($urandom_range(9) == 0);
    return s;
  endfunction

  function automatic slot_t mk(int slot, bit rp, bit cp, int rw, int cw, int rt, int ct,
                               bit fin);
    slot_t s;
    s.slot_number  = 10'(slot);
    s.ref_present  = rp;
    s.cand_present = cp;
    s.ref_weight   = 16'(rw);
    s.cand_weight  = 16'(cw);
    s.ref_top      = 10'(rt);
    s.cand_top     = 10'(ct);
    s.final_slot   = fin;
    return s;
  endfunction

  task automatic send_slot(slot_t s);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.slot_number  <= s.slot_number;
    in_ch.ref_present  <= s.ref_present;
    in_ch.cand_present <= s.cand_present;
    in_ch.ref_weight   <= s.ref_weight;
    in_ch.cand_weight  <= s.cand_weight;
    in_ch.ref_top      <= s.ref_top;
    in_ch.cand_top     <= s.cand_top;
    in_ch.final_slot   <= s.final_slot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_slot(s);
    if (s.final_slot || (s.slot_number != 0 && (s.ref_present || s.cand_present)))
      counted_slots++;
  endtask

  // Hold the input until every expected result is back, then let the back end settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [15:0] ce, logic [15:0] cd, logic [15:0] cw,
                              logic [23:0] thr);
    cfg_index_t  idx[4];
    logic [23:0] val[4];
    idx = '{CFG_COEFF_EXCESS, CFG_COEFF_DISJOINT, CFG_COEFF_WEIGHT, CFG_THRESHOLD};
    // upper bits of the 16-bit registers carry junk that must be dropped
    val = '{{8'($urandom), ce}, {8'($urandom), cd}, {8'($urandom), cw}, thr};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      sb.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // One comparison: mostly well-formed ascending slots within the genome tops, sometimes noise.
  task automatic run_genome_pair(int span, int skip_pct);
    slot_t s;
    int    rt;
    int    ct;
    int    hi;
    int    n;
    if ($urandom_range(99) < 15) begin
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        s = random_slot();
        if (i == n - 1) s.final_slot = 1'b1;
        send_slot(s);
      end
      return;
    end
    rt = $urandom_range(0, span);
    ct = $urandom_range(0, span);
    hi = (rt > ct) ? rt : ct;
    if (hi == 0) hi = 1;
    for (int slot = 1; slot <= hi; slot++) begin
      if (slot != hi && $urandom_range(99) < skip_pct) continue;
      s = random_slot();
      s.slot_number  = 10'(slot);
      s.ref_top      = 10'(rt);
      s.cand_top     = 10'(ct);
      s.ref_present  = (slot <= rt) && (slot == rt || $urandom_range(99) < 70);
      s.cand_present = (slot <= ct) && (slot == ct || $urandom_range(99) < 70);
      s.final_slot   = (slot == hi);
      send_slot(s);
    end
  endtask

  // Drive the distance past its cap within one comparison, with the widest weight gaps.
  task automatic run_saturating();
    slot_t s;
    int    n_m;
    int    n_e;
    int    n_d;
    int    pick;
    n_m = 40;
    n_e = 150;
    n_d = 150;
    while (n_m + n_e + n_d > 0) begin
      pick = $urandom_range(0, n_m + n_e + n_d - 1);
      s = random_slot();
      s.slot_number = 10'($urandom_range(1, 1023));
      if (pick < n_m) begin
        s.ref_present  = 1'b1;
        s.cand_present = 1'b1;
        s.ref_weight   = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        s.cand_weight  = ~s.ref_weight;
        n_m--;
      end else if (pick < n_m + n_e) begin
        s.ref_present  = 1'b1;
        s.cand_present = 1'b0;
        s.cand_top     = '0;
        n_e--;
      end else begin
        s.ref_present  = 1'b0;
        s.cand_present = 1'b1;
        s.ref_top      = 10'd1023;
        n_d--;
      end
      s.final_slot = (n_m + n_e + n_d == 0);
      send_slot(s);
    end
  endtask

  initial begin : stimulus
    slot_t       directed_q[$];
    int          target;
    logic [15:0] co[3];
    logic [23:0] thr;

    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_COEFF_EXCESS;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.slot_number  = '0;
    in_ch.ref_present  = 1'b0;
    in_ch.cand_present = 1'b0;
    in_ch.ref_weight   = '0;
    in_ch.cand_weight  = '0;
    in_ch.ref_top      = '0;
    in_ch.cand_top     = '0;
    in_ch.final_slot   = 1'b0;
    src_idle_pct       = 38;
    snk_idle_pct       = 73;
    counted_slots      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // final mark on slot zero with both present: nothing counted, result still due
    directed_q.push_back(mk(0, 1, 1, 32767, -32768, 1023, 1023, 1));
    // every class in one comparison, widest weight gaps both ways
    directed_q.push_back(mk(1, 1, 1, 32767, -32768, 1023, 10, 0));
    directed_q.push_back(mk(2, 1, 1, -32768, 32767, 1023, 10, 0));
    directed_q.push_back(mk(3, 1, 1, 0, 0, 1023, 10, 0));
    directed_q.push_back(mk(4, 0, 0, 123, -456, 1023, 10, 0));
    directed_q.push_back(mk(5, 1, 0, 1, 0, 1023, 10, 0));
    directed_q.push_back(mk(8, 0, 1, 0, 1, 1023, 10, 0));
    directed_q.push_back(mk(11, 1, 0, -1, 0, 1023, 10, 0));
    directed_q.push_back(mk(1023, 1, 0, 0, 0, 1023, 10, 1));
    // three excess genes, no matches: distance lands exactly on the default threshold
    directed_q.push_back(mk(1, 0, 1, 5, -5, 0, 1023, 0));
    directed_q.push_back(mk(2, 0, 1, 5, -5, 0, 1023, 0));
    directed_q.push_back(mk(3, 0, 1, 5, -5, 0, 1023, 1));
    // four excess genes: one step above the threshold
    for (int i = 1; i <= 4; i++)
      directed_q.push_back(mk(i, 1, 0, 0, 0, 1023, 0, i == 4));
    // mean gap truncates: gaps 1 and 2 over two matches
    directed_q.push_back(mk(9, 1, 1, 1, 0, 500, 500, 0));
    directed_q.push_back(mk(10, 1, 1, 0, 2, 500, 500, 1));
    // slot zero closes a comparison that already holds a match
    directed_q.push_back(mk(7, 1, 1, -1, 1, 20, 20, 0));
    directed_q.push_back(mk(0, 1, 1, 0, 0, 20, 20, 1));
    foreach (directed_q[i]) send_slot(directed_q[i]);

    counted_slots = 0;
    for (int seg = 0; seg < 6; seg++) begin
      src_idle_pct = (seg < 2) ? 38 : (seg < 4) ? 73 : 0;
      snk_idle_pct = (seg < 2) ? 73 : (seg < 4) ? 38 : 0;
      wait_drained();
      case (seg)
        0: program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        1: program_regs(16'h0000, 16'h0000, 16'h0000, 24'h000000);
        default: begin
          foreach (co[i])
            co[i] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 8191));
          thr = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
          program_regs(co[0], co[1], co[2], thr);
        end
      endcase
      if (seg == 0) run_saturating();
      if (seg == 4) run_genome_pair(1023, 85);
      target = counted_slots + 100;
      while (counted_slots < target) run_genome_pair(40, 20);
    end

    wait_drained();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
